@@ design/mbw_pkg.sv @@
// Shared types and constants for the MP4 box boundary walker.
`timescale 1ns / 1ps
`default_nettype none

package mbw_pkg;

  localparam int unsigned HDR_STORE_DEPTH = 16;
  localparam int unsigned HDR_IDX_W       = $clog2(HDR_STORE_DEPTH);

  localparam logic [4:0]  SHORT_HDR_LEN = 5'd8;
  localparam logic [4:0]  LONG_HDR_LEN  = 5'd16;
  localparam logic [31:0] LARGE_SIZE_MARK = 32'd1;

  localparam logic [31:0] TAG_STYP = 32'h7374_7970;
  localparam logic [31:0] TAG_MOOF = 32'h6D6F_6F66;
  localparam logic [31:0] TAG_MDAT = 32'h6D64_6174;

  typedef enum logic [2:0] {
    KIND_OTHER = 3'd0,
    KIND_STYP  = 3'd1,
    KIND_MOOF  = 3'd2,
    KIND_MDAT  = 3'd3,
    KIND_BAD   = 3'd4
  } box_kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_start;
    logic       discont;
  } in_item_t;

  typedef struct packed {
    box_kind_t   box_kind;
    logic [31:0] box_type;
    logic [63:0] box_size;
    logic [4:0]  header_len;
    logic        safe_boundary;
    logic [31:0] fragment_index;
  } out_item_t;

endpackage

`default_nettype wire

@@ design/mbw_if.sv @@
// Valid/ready channel interfaces for the byte input and the box report output.
`timescale 1ns / 1ps
`default_nettype none

interface mbw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_start;
  logic       discont;

  modport source (output valid, data_byte, buffer_start, discont, input ready);
  modport sink   (input valid, data_byte, buffer_start, discont, output ready);
endinterface

interface mbw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  box_kind;
  logic [31:0] box_type;
  logic [63:0] box_size;
  logic [4:0]  header_len;
  logic        safe_boundary;
  logic [31:0] fragment_index;

  modport source (output valid, box_kind, box_type, box_size, header_len,
                  safe_boundary, fragment_index, input ready);
  modport sink   (input valid, box_kind, box_type, box_size, header_len,
                  safe_boundary, fragment_index, output ready);
endinterface

`default_nettype wire

@@ design/mp4_box_boundary_walker_top.sv @@
// Top level of the MP4 top-level box boundary walker.
//
// The in_ch channel carries one byte of a fragmented MP4 stream per item,
// with a buffer_start mark for the first byte of each delivered buffer and
// a discont mark that clears parser progress and the media-seen flag before
// the byte is handled. The out_ch channel carries one item per completed box
// header: kind, raw type, size, header length, the running styp count, and
// for styp boxes the safe boundary flag.
// The block takes one byte per cycle while the receiver keeps up. A byte is
// accepted into the input register, is parsed by a single layer of logic
// against the header store and counters, and any report lands in the result
// register, from which it shows on out_ch until the receiver takes it.
// Bytes inside a payload and partial header bytes give no item.
// A size below the header length gives one report of kind invalid, and every
// later byte is then consumed without effect until reset.
// Reset clears all control state and both handshake registers; the header
// byte store is not cleared since only bytes of the current header are read.
// When the receiver stalls, the report is held in the result register and
// parsing pauses. One more byte may still be taken into the input register;
// after that in_ch.ready drops until the report is taken, and nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module mp4_box_boundary_walker_top (
  input  wire logic clk,
  input  wire logic rst,
  mbw_in_if.sink    in_ch,
  mbw_out_if.source out_ch
);

  mbw_pkg::in_item_t  item;
  mbw_pkg::out_item_t res;
  logic               item_valid;
  logic               res_valid;
  logic               can_load;
  logic               advance;

  // The held byte moves on whenever the result register can take a report.
  assign advance = item_valid && can_load;

  mbw_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  mbw_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  mbw_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

@@ design/mbw_in_reg.sv @@
// Input register that holds one accepted stream byte until the parser takes it.
`timescale 1ns / 1ps
`default_nettype none

module mbw_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  mbw_in_if.sink             in_ch,
  input  wire logic          advance,
  output logic               item_valid,
  output mbw_pkg::in_item_t  item
);

  assign in_ch.ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.data_byte    <= in_ch.data_byte;
      item.buffer_start <= in_ch.buffer_start;
      item.discont      <= in_ch.discont;
    end
  end

endmodule

`default_nettype wire

@@ design/mbw_core.sv @@
// Box header collector, payload skip counter and styp boundary bookkeeping.
`timescale 1ns / 1ps
`default_nettype none

module mbw_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  mbw_pkg::in_item_t  item,
  output logic               res_valid,
  output mbw_pkg::out_item_t res
);

  logic [7:0]  hdr_store [mbw_pkg::HDR_STORE_DEPTH];
  logic [4:0]  header_fill, header_fill_next;
  logic [63:0] skip_remaining, skip_remaining_next;
  logic        media_seen, media_seen_next;
  logic        parser_halted, parser_halted_next;
  logic        carried_over, carried_over_next;
  logic        at_buf_start, at_buf_start_next;
  logic [31:0] styp_counter, styp_counter_next;

  logic [4:0]  fill_eff;
  logic [63:0] skip_eff;
  logic        media_eff;
  logic        take_byte;
  logic [4:0]  fill_inc;
  logic [31:0] size32;
  logic        long_hdr;
  logic [4:0]  needed;
  logic        hdr_done;
  logic [63:0] size;
  logic [31:0] btype;

  // A discontinuity clears progress before the byte is looked at.
  assign fill_eff  = item.discont ? '0 : header_fill;
  assign skip_eff  = item.discont ? '0 : skip_remaining;
  assign media_eff = item.discont ? 1'b0 : media_seen;

  assign take_byte = !parser_halted && (skip_eff == '0);
  assign fill_inc  = fill_eff + 5'd1;

  assign size32   = {hdr_store[0], hdr_store[1], hdr_store[2], hdr_store[3]};
  assign long_hdr = (fill_inc >= mbw_pkg::SHORT_HDR_LEN) && (size32 == mbw_pkg::LARGE_SIZE_MARK);
  assign needed   = long_hdr ? mbw_pkg::LONG_HDR_LEN : mbw_pkg::SHORT_HDR_LEN;
  assign hdr_done = take_byte && (fill_inc == needed);

  // The byte in flight completes the last field, so it is spliced in here.
  assign size  = long_hdr ?
                 {hdr_store[8], hdr_store[9], hdr_store[10], hdr_store[11],
                  hdr_store[12], hdr_store[13], hdr_store[14], item.data_byte} :
                 {32'd0, size32};
  assign btype = long_hdr ?
                 {hdr_store[4], hdr_store[5], hdr_store[6], hdr_store[7]} :
                 {hdr_store[4], hdr_store[5], hdr_store[6], item.data_byte};

  always_comb begin
    header_fill_next    = fill_eff;
    skip_remaining_next = skip_eff;
    media_seen_next     = media_eff;
    parser_halted_next  = parser_halted;
    carried_over_next   = carried_over;
    at_buf_start_next   = at_buf_start;
    styp_counter_next   = styp_counter;

    res_valid              = 1'b0;
    res.box_kind           = mbw_pkg::KIND_OTHER;
    res.box_type           = btype;
    res.box_size           = size;
    res.header_len         = needed;
    res.safe_boundary      = 1'b0;
    res.fragment_index     = styp_counter;

    if (!parser_halted && (skip_eff != '0)) begin
      skip_remaining_next = skip_eff - 64'd1;
    end else if (take_byte) begin
      if (fill_eff == '0) begin
        at_buf_start_next = item.buffer_start;
        carried_over_next = 1'b0;
      end else if (item.buffer_start) begin
        carried_over_next = 1'b1;
      end
      header_fill_next = fill_inc;

      if (hdr_done) begin
        res_valid = 1'b1;
        if (size < {59'd0, needed}) begin
          parser_halted_next = 1'b1;
          res.box_kind       = mbw_pkg::KIND_BAD;
        end else begin
          if (btype == mbw_pkg::TAG_STYP) begin
            res.box_kind      = mbw_pkg::KIND_STYP;
            res.safe_boundary = !media_eff || carried_over_next || at_buf_start_next;
            styp_counter_next = styp_counter + 32'd1;
          end else if (btype == mbw_pkg::TAG_MOOF) begin
            res.box_kind    = mbw_pkg::KIND_MOOF;
            media_seen_next = 1'b1;
          end else if (btype == mbw_pkg::TAG_MDAT) begin
            res.box_kind    = mbw_pkg::KIND_MDAT;
            media_seen_next = 1'b1;
          end
          skip_remaining_next = size - {59'd0, needed};
          header_fill_next    = '0;
        end
        res.fragment_index = styp_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_fill    <= '0;
      skip_remaining <= '0;
      media_seen     <= 1'b0;
      parser_halted  <= 1'b0;
      carried_over   <= 1'b0;
      at_buf_start   <= 1'b1;
      styp_counter   <= '0;
    end else if (advance) begin
      header_fill    <= header_fill_next;
      skip_remaining <= skip_remaining_next;
      media_seen     <= media_seen_next;
      parser_halted  <= parser_halted_next;
      carried_over   <= carried_over_next;
      at_buf_start   <= at_buf_start_next;
      styp_counter   <= styp_counter_next;
    end
  end

  // Header bytes carry no reset; only bytes of the current header are read.
  always_ff @(posedge clk) begin
    if (advance && take_byte) begin
      hdr_store[fill_eff[mbw_pkg::HDR_IDX_W-1:0]] <= item.data_byte;
    end
  end

endmodule

`default_nettype wire

@@ design/mbw_out_reg.sv @@
// Result register that holds one box report until the receiver takes it.
`timescale 1ns / 1ps
`default_nettype none

module mbw_out_reg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire logic           res_valid,
  input  mbw_pkg::out_item_t  res,
  output logic                can_load,
  mbw_out_if.source           out_ch
);

  mbw_pkg::out_item_t held;
  logic               held_valid;

  assign can_load = !held_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (advance) begin
      held_valid <= res_valid;
    end else if (out_ch.ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      held <= res;
    end
  end

  assign out_ch.valid          = held_valid;
  assign out_ch.box_kind       = held.box_kind;
  assign out_ch.box_type       = held.box_type;
  assign out_ch.box_size       = held.box_size;
  assign out_ch.header_len     = held.header_len;
  assign out_ch.safe_boundary  = held.safe_boundary;
  assign out_ch.fragment_index = held.fragment_index;

endmodule

`default_nettype wire

@@ design/mbw_checker.sv @@
// Port-level checks on the box report channel, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mbw_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  box_kind,
  input wire logic [63:0] box_size,
  input wire logic [4:0]  header_len,
  input wire logic        safe_boundary
);

  // A stalled report keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(box_size) && $stable(box_kind))
    else $error("box report changed while stalled");

  a_hdr_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (header_len == mbw_pkg::SHORT_HDR_LEN) ||
                  (header_len == mbw_pkg::LONG_HDR_LEN))
    else $error("header length is neither 8 nor 16");

  a_size_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (box_kind != mbw_pkg::KIND_BAD) |-> box_size >= {59'd0, header_len})
    else $error("valid box reported with size below its header length");

  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && (box_kind == mbw_pkg::KIND_BAD) |->
      (box_size < {59'd0, header_len}) && !safe_boundary)
    else $error("invalid-size report is inconsistent");

  a_safe_styp: assert property (@(posedge clk) disable iff (rst)
    out_valid && safe_boundary |-> box_kind == mbw_pkg::KIND_STYP)
    else $error("safe boundary flagged on a box other than styp");

endmodule

bind mp4_box_boundary_walker_top mbw_checker u_mbw_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .box_kind      (out_ch.box_kind),
  .box_size      (out_ch.box_size),
  .header_len    (out_ch.header_len),
  .safe_boundary (out_ch.safe_boundary)
);

`default_nettype wire

@@ verif/mp4_box_boundary_walker_top_test.sv @@
// Self-checking testbench for the MP4 top-level box boundary walker.
`timescale 1ns / 1ps

module mp4_box_boundary_walker_top_test;

  // Generous bound on the length of the whole run.
  localparam int CYCLE_LIMIT = 200000;
  // Length of the deliberate receiver hold-off that fills the block up.
  localparam int LONG_STALL = 400;
  // Random bytes per idling phase; four phases give at least 1760 bytes.
  localparam int PHASE_BYTES = 440;

  logic clk = 1'b0;
  logic rst;

  mbw_in_if  in_ch ();
  mbw_out_if out_ch ();

  mp4_box_boundary_walker_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Bytes waiting to be offered, and box reports waiting to be matched.
  mbw_pkg::in_item_t  pending_bytes[$];
  mbw_pkg::out_item_t expected_reports[$];

  int  bytes_queued = 0;
  int  bytes_launched = 0;
  int  bytes_accepted = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  stall_requests = 0;
  int  stalls_served = 0;
  int  hold_left = 0;
  // Set when the next byte must carry discont, to abandon a header or a skip.
  logic need_disc = 1'b0;

  // Shadow copy of the walker's state, as it stands right after reset.
  logic [7:0]  hdr_store [16];
  logic [4:0]  hdr_fill = 5'd0;
  logic [63:0] skip_left = 64'd0;
  logic        media_seen = 1'b0;
  logic        halted = 1'b0;
  logic        carried_over = 1'b0;
  logic        at_buf_start = 1'b1;
  logic [31:0] styp_count = 32'd0;

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    $display("MISMATCH at cycle %0d: %s: got %0h, expected %0h",
             cycle_count, what, got_v, want_v);
    mismatch_count++;
  endtask

  // Advances the shadow state by one accepted byte and queues the box report
  // that the byte causes, if any.
  task automatic predict_box_report(input mbw_pkg::in_item_t it);
    logic [31:0] size_field;
    logic [63:0] box_size;
    logic [31:0] box_type;
    logic [4:0]  needed;
    mbw_pkg::out_item_t rep;
    // A discontinuity drops any partial header and any payload still to skip.
    if (it.discont) begin
      hdr_fill = 5'd0;
      skip_left = 64'd0;
      media_seen = 1'b0;
    end
    if (halted) return;
    if (skip_left != 64'd0) begin
      skip_left = skip_left - 64'd1;
      return;
    end
    // Track where the header began relative to buffer boundaries.
    if (hdr_fill == 5'd0) begin
      at_buf_start = it.buffer_start;
      carried_over = 1'b0;
    end else if (it.buffer_start) begin
      carried_over = 1'b1;
    end
    hdr_store[hdr_fill[3:0]] = it.data_byte;
    hdr_fill = hdr_fill + 5'd1;
    size_field = {hdr_store[0], hdr_store[1], hdr_store[2], hdr_store[3]};
    needed = mbw_pkg::SHORT_HDR_LEN;
    if (hdr_fill >= mbw_pkg::SHORT_HDR_LEN && size_field == mbw_pkg::LARGE_SIZE_MARK)
      needed = mbw_pkg::LONG_HDR_LEN;
    if (hdr_fill < needed) return;
    box_size = {32'd0, size_field};
    if (size_field == mbw_pkg::LARGE_SIZE_MARK) begin
      box_size = {hdr_store[8], hdr_store[9], hdr_store[10], hdr_store[11],
                  hdr_store[12], hdr_store[13], hdr_store[14], hdr_store[15]};
    end
    box_type = {hdr_store[4], hdr_store[5], hdr_store[6], hdr_store[7]};
    rep.safe_boundary = 1'b0;
    if (box_size < {59'd0, needed}) begin
      // Size smaller than its own header: report once and stop parsing.
      halted = 1'b1;
      rep.box_kind = mbw_pkg::KIND_BAD;
    end else begin
      if (box_type == mbw_pkg::TAG_STYP) begin
        rep.box_kind = mbw_pkg::KIND_STYP;
        rep.safe_boundary = !media_seen || carried_over || at_buf_start;
        styp_count = styp_count + 32'd1;
      end else if (box_type == mbw_pkg::TAG_MOOF) begin
        rep.box_kind = mbw_pkg::KIND_MOOF;
        media_seen = 1'b1;
      end else if (box_type == mbw_pkg::TAG_MDAT) begin
        rep.box_kind = mbw_pkg::KIND_MDAT;
        media_seen = 1'b1;
      end else begin
        rep.box_kind = mbw_pkg::KIND_OTHER;
      end
      skip_left = box_size - {59'd0, needed};
      hdr_fill = 5'd0;
    end
    rep.box_type = box_type;
    rep.box_size = box_size;
    rep.header_len = needed;
    rep.fragment_index = styp_count;
    expected_reports.push_back(rep);
  endtask

  // Queues one byte for the driver; a pending discont request rides on it.
  task automatic queue_byte(input logic [7:0] b, input logic bs, input logic dc);
    mbw_pkg::in_item_t it;
    it.data_byte = b;
    it.buffer_start = bs;
    it.discont = dc | need_disc;
    need_disc = 1'b0;
    pending_bytes.push_back(it);
    bytes_queued++;
  endtask

  // Queues a box header followed by payload_n payload bytes. A payload_n
  // shorter than the real payload leaves the block skipping.
  task automatic queue_box(input logic [31:0] box_type, input logic [63:0] box_size,
                           input logic long_hdr, input int payload_n, input logic bs_first);
    logic [127:0] hdr;
    int n;
    n = long_hdr ? 16 : 8;
    if (long_hdr) hdr = {mbw_pkg::LARGE_SIZE_MARK, box_type, box_size};
    else hdr = {box_size[31:0], box_type, 64'd0};
    for (int i = 0; i < n; i++) begin
      queue_byte(hdr[127 - 8 * i -: 8], (i == 0) ? bs_first : ($urandom_range(0, 5) == 0),
                 1'b0);
    end
    for (int i = 0; i < payload_n; i++) begin
      queue_byte(8'($urandom), $urandom_range(0, 5) == 0, 1'b0);
    end
  endtask

  // Random stream, mostly well-formed boxes with random content. Huge boxes,
  // abandoned payloads and partial headers are always cut short by a
  // discontinuity, so the block never halts and never waits on a huge skip.
  task automatic queue_random_stream(input int n_bytes);
    int stop;
    int pick;
    int len;
    int m;
    logic [31:0] box_type;
    logic [63:0] box_size;
    logic [127:0] hdr;
    logic bs;
    stop = bytes_queued + n_bytes;
    while (bytes_queued < stop) begin
      case ($urandom_range(0, 4))
        0, 4: box_type = mbw_pkg::TAG_STYP;
        1: box_type = mbw_pkg::TAG_MOOF;
        2: box_type = mbw_pkg::TAG_MDAT;
        default: box_type = $urandom;
      endcase
      bs = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 9) == 0) need_disc = 1'b1;
      pick = $urandom_range(0, 99);
      len = $urandom_range(0, 24);
      if (pick < 60) begin
        queue_box(box_type, 64'(8 + len), 1'b0, len, bs);
      end else if (pick < 75) begin
        queue_box(box_type, 64'(16 + len), 1'b1, len, bs);
      end else if (pick < 83) begin
        // Huge payload: the skip is abandoned after a few bytes.
        if ($urandom_range(0, 1) == 0) begin
          box_size = {32'd0, 32'h8000_0000 | $urandom};
          queue_box(box_type, box_size, 1'b0, $urandom_range(0, 10), bs);
        end else begin
          box_size = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
          if ($urandom_range(0, 3) == 0) box_size = 64'hFFFF_FFFF_FFFF_FFFF;
          queue_box(box_type, box_size, 1'b1, $urandom_range(0, 10), bs);
        end
        need_disc = 1'b1;
      end else if (pick < 90) begin
        // Ordinary box whose payload is cut by a discontinuity.
        len = $urandom_range(2, 24);
        queue_box(box_type, 64'(8 + len), 1'b0, $urandom_range(0, len - 1), bs);
        need_disc = 1'b1;
      end else begin
        // Broken header. Eight or more bytes must announce a large size, or
        // they would complete a header with a random size.
        m = $urandom_range(1, 15);
        hdr = {$urandom, box_type, $urandom, $urandom};
        if (m >= 8) hdr[127:96] = mbw_pkg::LARGE_SIZE_MARK;
        for (int i = 0; i < m; i++) begin
          queue_byte(hdr[127 - 8 * i -: 8], $urandom_range(0, 5) == 0, 1'b0);
        end
        need_disc = 1'b1;
      end
    end
  endtask

  // Holds the sender until every queued byte is taken and every report is in.
  task automatic wait_drained;
    while (pending_bytes.size() != 0 || bytes_accepted != bytes_launched) @(posedge clk);
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // Byte driver: offers the next pending byte at the falling edge once the
  // previous one has been taken, idling at the rate of the current phase.
  always @(negedge clk) begin : byte_driver
    logic              nv;
    mbw_pkg::in_item_t nx;
    nv = in_ch.valid;
    nx.data_byte = in_ch.data_byte;
    nx.buffer_start = in_ch.buffer_start;
    nx.discont = in_ch.discont;
    if (rst) begin
      nv = 1'b0;
    end else if (!in_ch.valid || bytes_accepted == bytes_launched) begin
      nv = 1'b0;
      if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nx = pending_bytes.pop_front();
        nv = 1'b1;
        bytes_launched++;
      end
    end
    in_ch.valid <= nv;
    in_ch.data_byte <= nx.data_byte;
    in_ch.buffer_start <= nx.buffer_start;
    in_ch.discont <= nx.discont;
  end

  // Report receiver: random stalls per phase, plus a long hold-off on request
  // that is counted down here so the sender keeps pushing meanwhile.
  always @(negedge clk) begin : report_receiver
    if (stall_requests != stalls_served) begin
      stalls_served++;
      hold_left = LONG_STALL;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: at each rising edge, accepted bytes feed the predictor and
  // accepted reports are checked field by field against the oldest prediction.
  always @(posedge clk) begin : channel_monitor
    mbw_pkg::in_item_t  seen;
    mbw_pkg::out_item_t got;
    mbw_pkg::out_item_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("mp4_box_boundary_walker_top_test failed");
      $finish;
    end else if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        seen.data_byte = in_ch.data_byte;
        seen.buffer_start = in_ch.buffer_start;
        seen.discont = in_ch.discont;
        predict_box_report(seen);
        bytes_accepted++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.box_kind = mbw_pkg::box_kind_t'(out_ch.box_kind);
        got.box_type = out_ch.box_type;
        got.box_size = out_ch.box_size;
        got.header_len = out_ch.header_len;
        got.safe_boundary = out_ch.safe_boundary;
        got.fragment_index = out_ch.fragment_index;
        if (expected_reports.size() == 0) begin
          report_mismatch("box report with none expected, type", 64'(got.box_type), 64'd0);
        end else begin
          want = expected_reports.pop_front();
          if (got.box_kind != want.box_kind)
            report_mismatch("box_kind", 64'(got.box_kind), 64'(want.box_kind));
          if (got.box_type != want.box_type)
            report_mismatch("box_type", 64'(got.box_type), 64'(want.box_type));
          if (got.box_size != want.box_size)
            report_mismatch("box_size", got.box_size, want.box_size);
          if (got.header_len != want.header_len)
            report_mismatch("header_len", 64'(got.header_len), 64'(want.header_len));
          if (got.safe_boundary != want.safe_boundary)
            report_mismatch("safe_boundary", 64'(got.safe_boundary),
                            64'(want.safe_boundary));
          if (got.fragment_index != want.fragment_index)
            report_mismatch("fragment_index", 64'(got.fragment_index),
                            64'(want.fragment_index));
        end
      end
    end
  end

  initial begin : stimulus
    int variant;
    logic [31:0] bad_type;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.buffer_start = 1'b0;
    in_ch.discont = 1'b0;
    out_ch.ready = 1'b0;
    rst = 1'b1;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Directed: a styp at a buffer start before any media, then an mdat with
    // a large-size header whose buffer boundary falls inside the header.
    queue_box(mbw_pkg::TAG_STYP, 64'd8, 1'b0, 0, 1'b1);
    queue_box(mbw_pkg::TAG_MDAT, 64'd16, 1'b1, 0, 1'b0);
    pending_bytes[pending_bytes.size() - 1].buffer_start = 1'b1;
    pending_bytes[0].data_byte = 8'h00;
    wait_drained();

    // Phase with no idling; the long receiver hold-off lands here while the
    // sender keeps offering bytes, so the block fills and stalls its input.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    queue_random_stream(PHASE_BYTES);
    stall_requests++;
    wait_drained();

    // Sender idle most of the time.
    send_idle_pct = 62;
    recv_stall_pct = 0;
    queue_random_stream(PHASE_BYTES);
    wait_drained();

    // Receiver stalling most of the time, with one more long hold-off.
    send_idle_pct = 0;
    recv_stall_pct = 62;
    queue_random_stream(PHASE_BYTES);
    stall_requests++;
    wait_drained();

    // Both sides idling now and then.
    send_idle_pct = 22;
    recv_stall_pct = 22;
    queue_random_stream(PHASE_BYTES);
    wait_drained();

    // Invalid size comes last since it halts the block until reset: either a
    // zero size, a short size below eight, or a large size below sixteen.
    // The trailing bytes, discontinuities among them, must give nothing.
    case ($urandom_range(0, 2))
      0: bad_type = mbw_pkg::TAG_STYP;
      1: bad_type = mbw_pkg::TAG_MOOF;
      default: bad_type = $urandom;
    endcase
    variant = $urandom_range(0, 2);
    if (variant == 0) queue_box(bad_type, 64'd0, 1'b0, 0, 1'b0);
    else if (variant == 1) queue_box(bad_type, 64'($urandom_range(2, 7)), 1'b0, 0, 1'b1);
    else queue_box(bad_type, 64'($urandom_range(0, 15)), 1'b1, 0, 1'b0);
    for (int i = 0; i < 24; i++) begin
      queue_byte(8'($urandom), $urandom_range(0, 3) == 0, (i == 3) || ($urandom_range(0, 5) == 0));
    end
    wait_drained();

    // Leave room for any stray report to show up.
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("mp4_box_boundary_walker_top_test passed");
    end else begin
      $display("mp4_box_boundary_walker_top_test failed");
    end
    $finish;
  end

endmodule

@@ mp4_box_boundary_walker_top.f @@
design/mbw_pkg.sv
design/mbw_if.sv
design/mbw_in_reg.sv
design/mbw_core.sv
design/mbw_out_reg.sv
design/mp4_box_boundary_walker_top.sv
design/mbw_checker.sv
verif/mp4_box_boundary_walker_top_test.sv
